@@ design/v3a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package v3a_pkg;

    typedef enum logic [3:0] {
        ACT_ADD   = 4'd0,
        ACT_SUB   = 4'd1,
        ACT_MUL   = 4'd2,
        ACT_DIV   = 4'd3,
        ACT_SCALE = 4'd4,
        ACT_DIVS  = 4'd5,
        ACT_ADDS  = 4'd6,
        ACT_SUBS  = 4'd7,
        ACT_CROSS = 4'd8,
        ACT_DOT   = 4'd9,
        ACT_MAG   = 4'd10,
        ACT_NORM  = 4'd11,
        ACT_EQ    = 4'd12
    } action_t;

    // control travelling beside each item
    typedef struct packed {
        logic    valid;
        action_t act;
        logic    eq;
        logic    zd;
        logic    st;
    } v3a_ctl_t;

    // normalize epsilon is one unit divided by this
    localparam int EPS_RECIP = 100000;

endpackage

`default_nettype wire

@@ design/v3a_arith.sv @@
`timescale 1ns / 1ps
`default_nettype none

// front end: input register, products, sums, truncation, saturation
module v3a_arith #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  v3a_pkg::action_t    in_act,
    input  logic [3*W-1:0]      in_a,
    input  logic [3*W-1:0]      in_b,
    input  logic [W-1:0]        in_s,
    output v3a_pkg::v3a_ctl_t   out_ctl,
    output logic [4*W-1:0]      out_res,
    output logic [3*W-1:0]      out_a,
    output logic [3*W-1:0]      out_den,
    output logic [2*W-1:0]      out_sq
);
    import v3a_pkg::*;

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic [SW-1:0] RND  = {{(SW-F){1'b0}}, {F{1'b1}}};

    typedef logic signed [W-1:0]  word_t;
    typedef logic signed [W:0]    lin_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;

    function automatic logic fits_sw(input logic [SW-1:0] x);
        return (x[SW-1:W-1] == '0) || (x[SW-1:W-1] == '1);
    endfunction

    function automatic logic [W-1:0] clamp_sw(input logic [SW-1:0] x);
        if (fits_sw(x))
            return x[W-1:0];
        return x[SW-1] ? MINW : MAXW;
    endfunction

    function automatic logic [W-1:0] clamp_lin(input logic [W:0] x);
        if (x[W] == x[W-1])
            return x[W-1:0];
        return x[W] ? MINW : MAXW;
    endfunction

    // stage 1: input register
    v3a_ctl_t ctl1_reg;
    word_t    a1_reg [0:2];
    word_t    b1_reg [0:2];
    word_t    s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg.valid <= in_valid;
            ctl1_reg.act   <= in_act;
            ctl1_reg.eq    <= 1'b0;
            ctl1_reg.zd    <= 1'b0;
            ctl1_reg.st    <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= in_a[i*W +: W];
                b1_reg[i] <= in_b[i*W +: W];
            end
            s1_reg <= in_s;
        end
    end

    // stage 2: operand select and products
    word_t qa [0:2];
    word_t qb [0:2];
    word_t ra [0:2];
    word_t rb [0:2];
    lin_t  lin [0:2];
    word_t den [0:2];
    logic  eq_c;
    logic  zd_c;

    always_comb
    begin
        eq_c = 1'b0;
        zd_c = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            qa[i]  = '0;
            qb[i]  = '0;
            ra[i]  = '0;
            rb[i]  = '0;
            lin[i] = '0;
            den[i] = '0;
        end
        case (ctl1_reg.act)
            ACT_ADD:
                for (int i = 0; i < 3; i++)
                    lin[i] = {a1_reg[i][W-1], a1_reg[i]} + {b1_reg[i][W-1], b1_reg[i]};
            ACT_SUB:
                for (int i = 0; i < 3; i++)
                    lin[i] = {a1_reg[i][W-1], a1_reg[i]} - {b1_reg[i][W-1], b1_reg[i]};
            ACT_ADDS:
                for (int i = 0; i < 3; i++)
                    lin[i] = {a1_reg[i][W-1], a1_reg[i]} + {s1_reg[W-1], s1_reg};
            ACT_SUBS:
                for (int i = 0; i < 3; i++)
                    lin[i] = {a1_reg[i][W-1], a1_reg[i]} - {s1_reg[W-1], s1_reg};
            ACT_MUL, ACT_DOT:
                for (int i = 0; i < 3; i++)
                begin
                    qa[i] = a1_reg[i];
                    qb[i] = b1_reg[i];
                end
            ACT_SCALE:
                for (int i = 0; i < 3; i++)
                begin
                    qa[i] = a1_reg[i];
                    qb[i] = s1_reg;
                end
            ACT_MAG, ACT_NORM:
                for (int i = 0; i < 3; i++)
                begin
                    qa[i] = a1_reg[i];
                    qb[i] = a1_reg[i];
                end
            ACT_CROSS:
            begin
                qa[0] = a1_reg[1]; qb[0] = b1_reg[2]; ra[0] = a1_reg[2]; rb[0] = b1_reg[1];
                qa[1] = a1_reg[2]; qb[1] = b1_reg[0]; ra[1] = a1_reg[0]; rb[1] = b1_reg[2];
                qa[2] = a1_reg[0]; qb[2] = b1_reg[1]; ra[2] = a1_reg[1]; rb[2] = b1_reg[0];
            end
            ACT_DIV:
            begin
                for (int i = 0; i < 3; i++)
                    den[i] = b1_reg[i];
                zd_c = (b1_reg[0] == '0) || (b1_reg[1] == '0) || (b1_reg[2] == '0);
            end
            ACT_DIVS:
            begin
                for (int i = 0; i < 3; i++)
                    den[i] = s1_reg;
                zd_c = (s1_reg == '0);
            end
            ACT_EQ:
                eq_c = (a1_reg[0] == b1_reg[0]) && (a1_reg[1] == b1_reg[1])
                       && (a1_reg[2] == b1_reg[2]);
            default:
            begin
                eq_c = 1'b0;
            end
        endcase
    end

    v3a_ctl_t ctl2_next;
    v3a_ctl_t ctl2_reg;
    prod_t    q2_reg [0:2];
    prod_t    r2_reg [0:2];
    lin_t     lin2_reg [0:2];
    word_t    a2_reg [0:2];
    word_t    den2_reg [0:2];

    always_comb
    begin
        ctl2_next    = ctl1_reg;
        ctl2_next.eq = eq_c;
        ctl2_next.zd = zd_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl2_reg <= ctl2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q2_reg[i]   <= qa[i] * qb[i];
                r2_reg[i]   <= ra[i] * rb[i];
                lin2_reg[i] <= lin[i];
                a2_reg[i]   <= a1_reg[i];
                den2_reg[i] <= den[i];
            end
        end
    end

    // stage 3: differences and three-way sum
    v3a_ctl_t ctl3_reg;
    sum_t     lane3_reg [0:2];
    sum_t     sum3_reg;
    lin_t     lin3_reg [0:2];
    word_t    a3_reg [0:2];
    word_t    den3_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl3_reg <= '0;
        else if (en)
            ctl3_reg <= ctl2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lane3_reg[i] <= q2_reg[i] - r2_reg[i];
                lin3_reg[i]  <= lin2_reg[i];
                a3_reg[i]    <= a2_reg[i];
                den3_reg[i]  <= den2_reg[i];
            end
            sum3_reg <= q2_reg[0] + q2_reg[1] + q2_reg[2];
        end
    end

    // stage 4: drop fraction bits, rounding toward zero
    sum_t lane_b [0:2];
    sum_t sum_b;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            lane_b[i] = lane3_reg[i] + $signed(lane3_reg[i][SW-1] ? RND : '0);
        sum_b = sum3_reg + $signed(sum3_reg[SW-1] ? RND : '0);
    end

    v3a_ctl_t         ctl4_reg;
    sum_t             tz4_reg [0:2];
    sum_t             tsum4_reg;
    logic [PW-1:0]    sq4_reg;
    lin_t             lin4_reg [0:2];
    word_t            a4_reg [0:2];
    word_t            den4_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl4_reg <= '0;
        else if (en)
            ctl4_reg <= ctl3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tz4_reg[i]  <= lane_b[i] >>> F;
                lin4_reg[i] <= lin3_reg[i];
                a4_reg[i]   <= a3_reg[i];
                den4_reg[i] <= den3_reg[i];
            end
            tsum4_reg <= sum_b >>> F;
            sq4_reg   <= sum3_reg[PW-1:0];
        end
    end

    // stage 5: saturation and result select
    logic [W-1:0] res_c [0:3];
    logic         st_c;

    always_comb
    begin
        st_c = 1'b0;
        for (int i = 0; i < 4; i++)
            res_c[i] = '0;
        case (ctl4_reg.act)
            ACT_ADD, ACT_SUB, ACT_ADDS, ACT_SUBS:
                for (int i = 0; i < 3; i++)
                begin
                    res_c[i] = clamp_lin(lin4_reg[i]);
                    st_c     = st_c | (lin4_reg[i][W] != lin4_reg[i][W-1]);
                end
            ACT_MUL, ACT_SCALE, ACT_CROSS:
                for (int i = 0; i < 3; i++)
                begin
                    res_c[i] = clamp_sw(tz4_reg[i]);
                    st_c     = st_c | !fits_sw(tz4_reg[i]);
                end
            ACT_DOT:
            begin
                res_c[3] = clamp_sw(tsum4_reg);
                st_c     = !fits_sw(tsum4_reg);
            end
            ACT_DIVS:
                if (ctl4_reg.zd)
                    for (int i = 0; i < 3; i++)
                        res_c[i] = a4_reg[i];
            default:
            begin
                st_c = 1'b0;
            end
        endcase
    end

    v3a_ctl_t      ctl5_next;
    v3a_ctl_t      ctl5_reg;
    logic [W-1:0]  res5_reg [0:3];
    word_t         a5_reg [0:2];
    word_t         den5_reg [0:2];
    logic [PW-1:0] sq5_reg;

    always_comb
    begin
        ctl5_next    = ctl4_reg;
        ctl5_next.st = st_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl5_reg <= ctl5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                res5_reg[i] <= res_c[i];
            for (int i = 0; i < 3; i++)
            begin
                a5_reg[i]   <= a4_reg[i];
                den5_reg[i] <= den4_reg[i];
            end
            sq5_reg <= sq4_reg;
        end
    end

    always_comb
    begin
        out_ctl = ctl5_reg;
        out_sq  = sq5_reg;
        for (int i = 0; i < 4; i++)
            out_res[i*W +: W] = res5_reg[i];
        for (int i = 0; i < 3; i++)
        begin
            out_a[i*W +: W]   = a5_reg[i];
            out_den[i*W +: W] = den5_reg[i];
        end
    end

endmodule

`default_nettype wire

@@ design/v3a_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// integer square root, one root bit per stage
module v3a_sqrt #(
    parameter int W      = 32,
    parameter int SIDE_W = 320
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  v3a_pkg::v3a_ctl_t in_ctl,
    input  logic [2*W-1:0]    in_x,
    input  logic [SIDE_W-1:0] in_side,
    output v3a_pkg::v3a_ctl_t out_ctl,
    output logic [W-1:0]      out_root,
    output logic [SIDE_W-1:0] out_side
);
    import v3a_pkg::*;

    v3a_ctl_t          ctl_reg  [0:W-1];
    logic [2*W-1:0]    x_reg    [0:W-1];
    logic [W+1:0]      rem_reg  [0:W-1];
    logic [W-1:0]      root_reg [0:W-1];
    logic [SIDE_W-1:0] side_reg [0:W-1];

    for (genvar k = 0; k < W; k++)
    begin : g_stage
        v3a_ctl_t          ctl_i;
        logic [2*W-1:0]    x_i;
        logic [W+1:0]      rem_i;
        logic [W-1:0]      root_i;
        logic [SIDE_W-1:0] side_i;
        logic [W+1:0]      remw;
        logic [W+1:0]      trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign ctl_i  = in_ctl;
            assign x_i    = in_x;
            assign rem_i  = '0;
            assign root_i = '0;
            assign side_i = in_side;
        end
        else
        begin : g_rest
            assign ctl_i  = ctl_reg[k-1];
            assign x_i    = x_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        assign remw  = {rem_i[W-1:0], x_i[2*W-1:2*W-2]};
        assign trial = {root_i, 2'b01};
        assign take  = (remw >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else if (en)
                ctl_reg[k] <= ctl_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= {x_i[2*W-3:0], 2'b00};
                rem_reg[k]  <= take ? remw - trial : remw;
                root_reg[k] <= {root_i[W-2:0], take};
                side_reg[k] <= side_i;
            end
        end
    end

    assign out_ctl  = ctl_reg[W-1];
    assign out_root = root_reg[W-1];
    assign out_side = side_reg[W-1];

endmodule

`default_nettype wire

@@ design/v3a_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// three restoring divider lanes, one quotient bit per stage
module v3a_div #(
    parameter int W      = 32,
    parameter int F      = 16,
    parameter int SIDE_W = 131
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  v3a_pkg::v3a_ctl_t in_ctl,
    input  logic [3*W-1:0]    in_num,
    input  logic [3*W-1:0]    in_den,
    input  logic [SIDE_W-1:0] in_side,
    output v3a_pkg::v3a_ctl_t out_ctl,
    output logic [3*(W+F)-1:0] out_quo,
    output logic [SIDE_W-1:0] out_side
);
    import v3a_pkg::*;

    localparam int N = W + F;

    v3a_ctl_t          ctl_reg  [0:N-1];
    logic [N-1:0]      nq_reg   [0:N-1][0:2];
    logic [W-1:0]      rem_reg  [0:N-1][0:2];
    logic [W-1:0]      den_reg  [0:N-1][0:2];
    logic [SIDE_W-1:0] side_reg [0:N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        v3a_ctl_t          ctl_i;
        logic [SIDE_W-1:0] side_i;
        logic [N-1:0]      nq_i  [0:2];
        logic [W-1:0]      rem_i [0:2];
        logic [W-1:0]      den_i [0:2];
        logic [W:0]        remw  [0:2];
        logic              take  [0:2];

        if (k == 0)
        begin : g_first
            assign ctl_i  = in_ctl;
            assign side_i = in_side;
            always_comb
            begin
                for (int l = 0; l < 3; l++)
                begin
                    nq_i[l]  = {in_num[l*W +: W], {F{1'b0}}};
                    rem_i[l] = '0;
                    den_i[l] = in_den[l*W +: W];
                end
            end
        end
        else
        begin : g_rest
            assign ctl_i  = ctl_reg[k-1];
            assign side_i = side_reg[k-1];
            always_comb
            begin
                for (int l = 0; l < 3; l++)
                begin
                    nq_i[l]  = nq_reg[k-1][l];
                    rem_i[l] = rem_reg[k-1][l];
                    den_i[l] = den_reg[k-1][l];
                end
            end
        end

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                remw[l] = {rem_i[l], nq_i[l][N-1]};
                take[l] = (remw[l] >= {1'b0, den_i[l]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else if (en)
                ctl_reg[k] <= ctl_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    nq_reg[k][l]  <= {nq_i[l][N-2:0], take[l]};
                    rem_reg[k][l] <= take[l] ? W'(remw[l] - {1'b0, den_i[l]})
                                             : remw[l][W-1:0];
                    den_reg[k][l] <= den_i[l];
                end
                side_reg[k] <= side_i;
            end
        end
    end

    assign out_ctl  = ctl_reg[N-1];
    assign out_side = side_reg[N-1];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            out_quo[l*N +: N] = nq_reg[N-1][l];
    end

endmodule

`default_nettype wire

@@ design/vector3_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-component vector ALU on signed fixed-point words (WORD_BITS wide,
// FRAC_BITS fraction bits, Q16.16 by default). An item carries two vectors,
// a scalar and an action in tuser; the result item carries a vector, a scalar
// and three flags. Products and sums are kept exact and then truncated toward
// zero and saturated. The block is fully pipelined and takes one item every
// clock unless the output stalls; each item passes through five front stages
// for products and sums, WORD_BITS stages of square root, one divisor set-up
// stage, WORD_BITS + FRAC_BITS stages of restoring division and the output
// register. Every action takes the same path, so results leave in order.
// While a result sits unclaimed on the master side the whole pipeline holds
// and s_tready is low.
module vector3_alu #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // ax, ay, az, bx, by, bz, scalar_in
    input  logic [((7*WORD_BITS+7)/8)*8-1:0]         s_tdata,
    // action
    input  logic [3:0]                               s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // rx, ry, rz, scalar_out, equal_flag, zero_divisor, saturated
    output logic [((4*WORD_BITS+3+7)/8)*8-1:0]       m_tdata
);
    import v3a_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int N     = W + F;
    localparam int OUT_W = ((4*W+3+7)/8)*8;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] QONE = W'(1 << F);
    localparam logic [W-1:0] QEPS = W'((1 << F) / EPS_RECIP);

    function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    // whole pipeline moves unless the output register is stuck
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // front end
    v3a_ctl_t       fe_ctl;
    logic [4*W-1:0] fe_res;
    logic [3*W-1:0] fe_a;
    logic [3*W-1:0] fe_den;
    logic [2*W-1:0] fe_sq;

    v3a_arith #(.W(W), .F(F)) u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_act   (action_t'(s_tuser)),
        .in_a     (s_tdata[3*W-1:0]),
        .in_b     (s_tdata[6*W-1:3*W]),
        .in_s     (s_tdata[7*W-1:6*W]),
        .out_ctl  (fe_ctl),
        .out_res  (fe_res),
        .out_a    (fe_a),
        .out_den  (fe_den),
        .out_sq   (fe_sq)
    );

    // square root of the sum of squares; the rest of the item rides alongside
    v3a_ctl_t        sq_ctl;
    logic [W-1:0]    sq_root;
    logic [10*W-1:0] sq_side;

    v3a_sqrt #(.W(W), .SIDE_W(10*W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctl   (fe_ctl),
        .in_x     (fe_sq),
        .in_side  ({fe_res, fe_den, fe_a}),
        .out_ctl  (sq_ctl),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // divisor set-up: magnitudes, quotient signs, magnitude result
    logic [W-1:0]   pa      [0:2];
    logic [W-1:0]   pden    [0:2];
    logic [W-1:0]   num_c   [0:2];
    logic [W-1:0]   dmag_c  [0:2];
    logic [2:0]     neg_c;
    logic [W-1:0]   nden;
    logic [4*W-1:0] res_c;
    logic           st_c;

    always_comb
    begin
        nden  = (sq_root <= QEPS) ? QONE : sq_root;
        res_c = sq_side[10*W-1:6*W];
        st_c  = sq_ctl.st;
        for (int i = 0; i < 3; i++)
        begin
            pa[i]    = sq_side[i*W +: W];
            pden[i]  = sq_side[3*W + i*W +: W];
            num_c[i] = mag_w(pa[i]);
            if (sq_ctl.act == ACT_NORM)
            begin
                dmag_c[i] = nden;
                neg_c[i]  = pa[i][W-1];
            end
            else
            begin
                dmag_c[i] = mag_w(pden[i]);
                neg_c[i]  = pa[i][W-1] ^ pden[i][W-1];
            end
        end
        if (sq_ctl.act == ACT_MAG)
        begin
            // root is below 2^W; top bit set means it exceeds the word
            res_c[3*W +: W] = sq_root[W-1] ? MAXW : sq_root;
            st_c            = sq_root[W-1];
        end
    end

    v3a_ctl_t       p_ctl_next;
    v3a_ctl_t       p_ctl_reg;
    logic [3*W-1:0] p_num_reg;
    logic [3*W-1:0] p_den_reg;
    logic [2:0]     p_neg_reg;
    logic [4*W-1:0] p_res_reg;

    always_comb
    begin
        p_ctl_next    = sq_ctl;
        p_ctl_next.st = st_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ctl_reg <= '0;
        end
        else if (en)
        begin
            p_ctl_reg <= p_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_num_reg[i*W +: W] <= num_c[i];
                p_den_reg[i*W +: W] <= dmag_c[i];
            end
            p_neg_reg <= neg_c;
            p_res_reg <= res_c;
        end
    end

    // division lanes
    v3a_ctl_t         dv_ctl;
    logic [3*N-1:0]   dv_quo;
    logic [4*W+2:0]   dv_side;

    v3a_div #(.W(W), .F(F), .SIDE_W(4*W+3)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctl   (p_ctl_reg),
        .in_num   (p_num_reg),
        .in_den   (p_den_reg),
        .in_side  ({p_neg_reg, p_res_reg}),
        .out_ctl  (dv_ctl),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // sign, saturation and final select
    logic [N-1:0]   q     [0:2];
    logic [W-1:0]   qv    [0:2];
    logic [2:0]     qov;
    logic           use_div;
    logic [4*W-1:0] fin_res;
    logic           fin_st;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q[i] = dv_quo[i*N +: N];
            if (dv_side[4*W+i])
            begin
                // a negative quotient may reach one unit further
                qov[i] = !((q[i][N-1:W-1] == '0)
                           || ((q[i][N-1:W-1] == (N-W+1)'(1)) && (q[i][W-2:0] == '0)));
                qv[i]  = qov[i] ? MINW : (~q[i][W-1:0] + 1'b1);
            end
            else
            begin
                qov[i] = (q[i][N-1:W-1] != '0);
                qv[i]  = qov[i] ? MAXW : q[i][W-1:0];
            end
        end
        use_div = ((dv_ctl.act == ACT_DIV) || (dv_ctl.act == ACT_DIVS)
                   || (dv_ctl.act == ACT_NORM)) && !dv_ctl.zd;
        if (use_div)
        begin
            fin_res = {{W{1'b0}}, qv[2], qv[1], qv[0]};
            fin_st  = dv_ctl.st | (|qov);
        end
        else
        begin
            fin_res = dv_side[4*W-1:0];
            fin_st  = dv_ctl.st;
        end
    end

    // output register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= OUT_W'({fin_st, dv_ctl.zd, dv_ctl.eq, fin_res});
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ design/v3a_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

module v3a_check #(
    parameter int W = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [((4*W+3+7)/8)*8-1:0]    m_tdata
);

    localparam int EQ_BIT = 4 * W;
    localparam int ZD_BIT = 4 * W + 1;
    localparam int ST_BIT = 4 * W + 2;

    // held result is not lost or altered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // pipeline takes nothing while the output is stuck
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");

    // zero divisor never comes with clamping or an equality hit
    a_zd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[ZD_BIT] |-> !m_tdata[EQ_BIT] && !m_tdata[ST_BIT])
        else $error("zero divisor with other flags");

    // equals result carries all-zero words
    a_eq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[EQ_BIT] |-> m_tdata[4*W-1:0] == '0)
        else $error("equals result with non-zero words");

    a_rst: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid in reset");

endmodule

bind vector3_alu v3a_check #(.W(WORD_BITS)) u_v3a_check (.*);

`default_nettype wire

@@ bench/vector3_alu_tb.sv @@
`timescale 1ns / 1ps

module vector3_alu_tb;
    import v3a_pkg::*;

    localparam int NUM_RANDOM  = 450;
    localparam int CALM_TAIL   = 60;        // last items sent with no idling
    localparam int DRAIN_WAIT  = 120;       // pipeline is 87 deep
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [127:0] wide_t;
    localparam wide_t WORD_MAX = 128'sh7fffffff;
    localparam wide_t WORD_MIN = -128'sh80000000;
    localparam logic signed [31:0] ONE_Q = 32'sh00010000;

    // one operand item as it goes into the block
    typedef struct {
        action_t           act;
        logic signed [31:0] a[3];
        logic signed [31:0] b[3];
        logic signed [31:0] s;
    } vec_op_t;

    // one result item as it leaves the block
    typedef struct {
        logic [31:0] r[3];
        logic [31:0] so;
        logic        eq;
        logic        zd;
        logic        st;
    } vec_res_t;

    // ---------------------------------------------------------------
    // Fixed-point helpers for the predictor (exact at 128 bits)
    // ---------------------------------------------------------------
    function automatic logic [31:0] clamp_word(input wide_t v, inout logic st);
        if (v > WORD_MAX)
        begin
            st = 1'b1;
            return 32'h7fffffff;
        end
        if (v < WORD_MIN)
        begin
            st = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // drop the fraction bits, truncating toward zero
    function automatic wide_t drop_frac(input wide_t v);
        wide_t m;
        m = (v < 0) ? -v : v;
        m = m >>> 16;
        return (v < 0) ? -m : m;
    endfunction

    // (n << 16) / d, d nonzero, toward zero, saturated
    function automatic logic [31:0] fix_div(input wide_t n, input wide_t d, inout logic st);
        wide_t mn, md, q;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q  = (mn <<< 16) / md;
        if ((n < 0) != (d < 0))
            q = -q;
        return clamp_word(q, st);
    endfunction

    function automatic wide_t floor_sqrt(input wide_t n);
        wide_t lo, hi, mid;
        lo = 0;
        hi = wide_t'(1) <<< 34;
        while (hi - lo > 1)
        begin
            mid = lo + ((hi - lo) >>> 1);
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // expected result of one item
    function automatic vec_res_t vector_result(input vec_op_t op);
        vec_res_t res;
        wide_t a[3], b[3], s, acc, m;
        logic st;
        st = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = op.a[i];
            b[i] = op.b[i];
            res.r[i] = '0;
        end
        s = op.s;
        res.so = '0;
        res.eq = 1'b0;
        res.zd = 1'b0;
        case (op.act)
            ACT_ADD:   for (int i = 0; i < 3; i++) res.r[i] = clamp_word(a[i] + b[i], st);
            ACT_SUB:   for (int i = 0; i < 3; i++) res.r[i] = clamp_word(a[i] - b[i], st);
            ACT_MUL:
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp_word(drop_frac(a[i] * b[i]), st);
            ACT_DIV:
                if (b[0] == 0 || b[1] == 0 || b[2] == 0)
                    res.zd = 1'b1;
                else
                    for (int i = 0; i < 3; i++) res.r[i] = fix_div(a[i], b[i], st);
            ACT_SCALE:
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp_word(drop_frac(a[i] * s), st);
            ACT_DIVS:
                if (s == 0)
                begin
                    res.zd = 1'b1;
                    for (int i = 0; i < 3; i++) res.r[i] = op.a[i];
                end
                else
                    for (int i = 0; i < 3; i++) res.r[i] = fix_div(a[i], s, st);
            ACT_ADDS:  for (int i = 0; i < 3; i++) res.r[i] = clamp_word(a[i] + s, st);
            ACT_SUBS:  for (int i = 0; i < 3; i++) res.r[i] = clamp_word(a[i] - s, st);
            ACT_CROSS:
            begin
                res.r[0] = clamp_word(drop_frac(a[1] * b[2] - a[2] * b[1]), st);
                res.r[1] = clamp_word(drop_frac(a[2] * b[0] - a[0] * b[2]), st);
                res.r[2] = clamp_word(drop_frac(a[0] * b[1] - a[1] * b[0]), st);
            end
            ACT_DOT:
                res.so = clamp_word(drop_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), st);
            ACT_MAG, ACT_NORM:
            begin
                acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                m = floor_sqrt(acc);
                if (op.act == ACT_MAG)
                    res.so = clamp_word(m, st);
                else
                begin
                    // epsilon is 65536/100000 in raw units, i.e. zero
                    if (m <= (wide_t'(65536) / EPS_RECIP))
                        m = wide_t'(65536);
                    for (int i = 0; i < 3; i++) res.r[i] = fix_div(a[i], m, st);
                end
            end
            ACT_EQ:
                res.eq = (op.a[0] == op.b[0] && op.a[1] == op.b[1] && op.a[2] == op.b[2]);
            default: ;
        endcase
        res.st = st;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: in-order queue of expected results
    // ---------------------------------------------------------------
    class vec_scoreboard;
        vec_res_t pending[$];
        int       errors;
        int       checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        function void note_item(input vec_op_t op);
            pending.push_back(vector_result(op));
        endfunction

        task check_result(input logic [135:0] data);
            vec_res_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            want = pending.pop_front();
            checked++;
            for (int i = 0; i < 3; i++)
                if (data[32*i +: 32] !== want.r[i])
                    report($sformatf("r[%0d] got %h want %h", i, data[32*i +: 32], want.r[i]));
            if (data[127:96] !== want.so)
                report($sformatf("scalar_out got %h want %h", data[127:96], want.so));
            if (data[128] !== want.eq)
                report($sformatf("equal_flag got %b want %b", data[128], want.eq));
            if (data[129] !== want.zd)
                report($sformatf("zero_divisor got %b want %b", data[129], want.zd));
            if (data[130] !== want.st)
                report($sformatf("saturated got %b want %b", data[130], want.st));
        endtask
    endclass

    // ---------------------------------------------------------------
    // DUT hookup
    // ---------------------------------------------------------------
    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;      // ax, ay, az, bx, by, bz, scalar_in
    logic [3:0]   s_tuser;      // action
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;      // rx, ry, rz, scalar_out, equal_flag, zero_divisor, saturated

    vector3_alu DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vec_scoreboard sb = new();
    vec_op_t       items[$];
    int            cycles = 0;
    int            sent   = 0;
    bit            feed_done = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
            if (clk)
                cycles++;
        end
    end

    // watchdog
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("vector3_alu regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom();
            2:       return $signed($urandom_range(0, 20 << 16)) - (10 <<< 16);
            3:       return $signed($urandom_range(0, 2000)) - 1000;
            4:       return 32'sh0;
            5:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            6:       return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
            default: return $signed($urandom_range(0, 1 << 24)) - (1 <<< 23);
        endcase
    endfunction

    function automatic vec_op_t make_op(input action_t act,
                                        input logic signed [31:0] ax, ay, az,
                                        input logic signed [31:0] bx, by, bz,
                                        input logic signed [31:0] s);
        vec_op_t op;
        op.act = act;
        op.a[0] = ax; op.a[1] = ay; op.a[2] = az;
        op.b[0] = bx; op.b[1] = by; op.b[2] = bz;
        op.s = s;
        return op;
    endfunction

    task automatic build_items();
        vec_op_t op;
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // directed: extremes, every action, divide by zero, tiny normalize, equals
        items.push_back(make_op(ACT_ADD, mx, mn, 5, mx, mn, 7, 0));
        items.push_back(make_op(ACT_SUB, mn, mx, 0, mx, mn, -1, 0));
        items.push_back(make_op(ACT_MUL, mx, mn, mn, mx, mx, mn, 0));
        items.push_back(make_op(ACT_MUL, ONE_Q, -3, 3 <<< 16, ONE_Q, ONE_Q, -ONE_Q, 0));
        items.push_back(make_op(ACT_DIV, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, ONE_Q, 0));
        items.push_back(make_op(ACT_DIV, 7 <<< 16, -7, mn, 2 <<< 16, 3, -1, 0));
        items.push_back(make_op(ACT_DIV, mx, mn, 1, 1, 1, mx, 0));
        items.push_back(make_op(ACT_SCALE, mx, mn, ONE_Q, 0, 0, 0, mn));
        items.push_back(make_op(ACT_SCALE, 3 <<< 16, -5, 9, 0, 0, 0, ONE_Q >>> 1));
        items.push_back(make_op(ACT_DIVS, mx, mn, 123, 0, 0, 0, 0));
        items.push_back(make_op(ACT_DIVS, mx, mn, -9 <<< 16, 0, 0, 0, -3 <<< 16));
        items.push_back(make_op(ACT_DIVS, mx, mn, 5, 0, 0, 0, 1));
        items.push_back(make_op(ACT_ADDS, mx, mn, 0, 0, 0, 0, mx));
        items.push_back(make_op(ACT_SUBS, mx, mn, 0, 0, 0, 0, mn));
        items.push_back(make_op(ACT_CROSS, ONE_Q, 0, 0, 0, ONE_Q, 0, 0));
        items.push_back(make_op(ACT_CROSS, mx, mn, mx, mn, mx, mn, 0));
        items.push_back(make_op(ACT_DOT, mn, mn, mn, mn, mn, mn, 0));
        items.push_back(make_op(ACT_DOT, 2 <<< 16, -3 <<< 16, 1, ONE_Q, ONE_Q, 1, 0));
        items.push_back(make_op(ACT_MAG, mn, mn, mn, 0, 0, 0, 0));
        items.push_back(make_op(ACT_MAG, 3 <<< 16, 4 <<< 16, 0, 0, 0, 0, 0));
        items.push_back(make_op(ACT_NORM, 0, 0, 0, 0, 0, 0, 0));
        items.push_back(make_op(ACT_NORM, 1, 0, -1, 0, 0, 0, 0));
        items.push_back(make_op(ACT_NORM, mx, mn, 3 <<< 16, 0, 0, 0, 0));
        items.push_back(make_op(ACT_EQ, mx, mn, 42, mx, mn, 42, 0));
        items.push_back(make_op(ACT_EQ, mx, mn, 42, mx, mn, 43, 0));
        // random part
        repeat (NUM_RANDOM)
        begin
            op = make_op(action_t'($urandom_range(0, 12)), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
            if (op.act == ACT_EQ && $urandom_range(0, 1))
            begin
                op.b = op.a;
                if ($urandom_range(0, 2) == 0)
                    op.b[$urandom_range(0, 2)][$urandom_range(0, 31)] ^= 1'b1;
            end
            items.push_back(op);
        end
    endtask

    // ---------------------------------------------------------------
    // Drivers: inputs change only by NBA at the rising edge
    // ---------------------------------------------------------------
    task automatic feed_items();
        int gap;
        gap = 0;
        while (sent < items.size())
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                sb.note_item(items[sent]);
                sent++;
            end
            // a start of an idle burst only where no offered item is left waiting
            if (gap == 0 && !(s_tvalid && !s_tready) && sent < items.size() - CALM_TAIL
                && $urandom_range(0, 9) == 0)
                gap = $urandom_range(1, 11);
            if (gap > 0 || sent >= items.size())
            begin
                if (gap > 0)
                    gap--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= items[sent].act;
                s_tdata  <= {items[sent].s, items[sent].b[2], items[sent].b[1],
                             items[sent].b[0], items[sent].a[2], items[sent].a[1],
                             items[sent].a[0]};
            end
        end
        feed_done = 1;
    endtask

    task automatic drain_results();
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (stall == 0 && sent < items.size() - CALM_TAIL && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 11);
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_ADD;
        m_tready = 1'b0;
        build_items();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        fork
            feed_items();
            drain_results();
        join_none
        wait (feed_done && sb.pending.size() == 0);
        // anything beyond this would be a spurious result
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("sent %0d items over all 13 actions, checked %0d results", sent, sb.checked);
        $display("idle bursts on both sides, quiet tail of %0d items", CALM_TAIL);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("vector3_alu regression: pass");
        else
            $display("vector3_alu regression: fail");
        $finish;
    end

endmodule
